// File: rtl/core/dpt_pkg.sv
// Shared types, constants and codes for the detector pairing table.
`timescale 1ns / 1ps
`default_nettype none
package dpt_pkg;

  localparam int SLOTS  = 32;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam logic [7:0] SLOTS_B = 8'(SLOTS);

  typedef enum logic [1:0] {
    CMD_PAIR   = 2'd0,
    CMD_MATCH  = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_PAIRED = 2'd1,
    STAT_FAIL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_QREAD,
    ST_RESP
  } state_e;

  // One stored slot, kind store above code store.
  typedef struct packed {
    logic [7:0] zone;
    logic [7:0] kind;
    logic [7:0] code_high;
    logic [7:0] code_mid;
    logic [7:0] code_low;
  } entry_t;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] code_low;
    logic [7:0] code_mid;
    logic [7:0] code_high;
    logic [7:0] detector_kind;
    logic [7:0] zone_kind;
    logic [7:0] slot;
  } req_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
    logic              set_valid;
  } wr_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } rd_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] slot_index;
    logic [7:0] entry_id;
    logic       entry_valid;
    entry_t     entry;
    logic [7:0] paired_count;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/core/dpt_store.sv
// Slot memory with registered read, per-slot valid flops and paired count.
`timescale 1ns / 1ps
`default_nettype none
module dpt_store (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dpt_pkg::wr_t               wr_i,
  input  wire dpt_pkg::rd_t               rd_i,
  output dpt_pkg::entry_t                 rdata_o,
  output logic [dpt_pkg::SLOTS-1:0]       valid_o,
  output logic [7:0]                      count_o
);
  import dpt_pkg::*;

  entry_t             mem_q [SLOTS];
  entry_t             rdata_q;
  logic [SLOTS-1:0]   vld_q;
  logic [7:0]         count_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  // Track valid marks and the count of set marks together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      count_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= wr_i.set_valid;
      if (wr_i.set_valid && !vld_q[wr_i.addr]) begin
        count_q <= count_q + 8'd1;
      end else if (!wr_i.set_valid && vld_q[wr_i.addr]) begin
        count_q <= count_q - 8'd1;
      end
    end
  end

  assign rdata_o = rdata_q;
  assign valid_o = vld_q;
  assign count_o = count_q;

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    8'($countones(vld_q)) == count_q)
    else $error("paired count out of step with valid marks");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SLOTS_B)
    else $error("paired count above slot total");

  a_insert_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i.en && wr_i.set_valid) |=> vld_q[$past(wr_i.addr)])
    else $error("insert did not set the valid mark");

endmodule
`default_nettype wire

// File: rtl/core/dpt_seq.sv
// Command sequencer: table scan, insert, delete and query over the slot memory.
`timescale 1ns / 1ps
`default_nettype none
module dpt_seq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  req_valid_i,
  output logic                       req_ready_o,
  input  wire dpt_pkg::req_t         req_i,
  output dpt_pkg::wr_t               wr_o,
  output dpt_pkg::rd_t               rd_o,
  input  wire dpt_pkg::entry_t       rdata_i,
  input  wire logic [dpt_pkg::SLOTS-1:0] valid_i,
  input  wire logic [7:0]            count_i,
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output dpt_pkg::res_t              res_o
);
  import dpt_pkg::*;

  state_e            state_q, state_d;
  req_t              req_q;
  logic [CNT_W-1:0]  addr_q, addr_d;
  logic [SLOT_W-1:0] prev_q, prev_d;
  logic              pend_q, pend_d;
  logic [SLOT_W-1:0] free_q, free_d;
  logic              free_found_q, free_found_d;
  res_t              res_q, res_d;

  logic              slot_ok;
  logic [SLOT_W-1:0] slot_idx;
  logic              hit;
  logic              prev_vld;
  logic              free_any;
  logic [SLOT_W-1:0] free_sel;
  entry_t            new_entry;

  assign slot_ok   = req_q.slot < SLOTS_B;
  assign slot_idx  = req_q.slot[SLOT_W-1:0];
  assign prev_vld  = valid_i[prev_q];
  assign hit       = pend_q && prev_vld && (rdata_i.code_mid == req_q.code_mid) &&
                     (rdata_i.code_high == req_q.code_high);
  assign free_any  = free_found_q || (pend_q && !prev_vld);
  assign free_sel  = free_found_q ? free_q : prev_q;
  assign new_entry = '{zone: req_q.zone_kind, kind: req_q.detector_kind,
                       code_high: req_q.code_high, code_mid: req_q.code_mid,
                       code_low: req_q.code_low};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      addr_q       <= '0;
      pend_q       <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      pend_q       <= pend_d;
      free_found_q <= free_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
    end
    prev_q <= prev_d;
    free_q <= free_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    prev_d       = prev_q;
    pend_d       = pend_q;
    free_d       = free_q;
    free_found_d = free_found_q;
    res_d        = res_q;
    wr_o         = '0;
    rd_o         = '0;
    req_ready_o  = 1'b0;
    res_valid_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          state_d = ST_START;
        end
      end

      ST_START: begin
        res_d         = '0;
        res_d.status  = STAT_FAIL;
        addr_d        = '0;
        pend_d        = 1'b0;
        free_found_d  = 1'b0;
        case (req_q.command)
          CMD_PAIR, CMD_MATCH: begin
            state_d = ST_SCAN;
          end
          CMD_DELETE: begin
            if (slot_ok) begin
              wr_o.en          = 1'b1;
              wr_o.addr        = slot_idx;
              wr_o.data        = '0;
              wr_o.set_valid   = 1'b0;
              res_d.status     = STAT_DONE;
              res_d.slot_index = req_q.slot;
            end
            state_d = ST_RESP;
          end
          CMD_QUERY: begin
            if (slot_ok) begin
              rd_o.en   = 1'b1;
              rd_o.addr = slot_idx;
              state_d   = ST_QREAD;
            end else begin
              state_d   = ST_RESP;
            end
          end
          default: state_d = ST_RESP;
        endcase
      end

      ST_SCAN: begin
        if (hit) begin
          // Lowest matching valid slot wins; leave the entry as stored.
          res_d.status      = (req_q.command == CMD_PAIR) ? STAT_PAIRED : STAT_DONE;
          res_d.slot_index  = 8'(prev_q);
          res_d.entry_id    = 8'(prev_q) + 8'd1;
          res_d.entry_valid = 1'b1;
          res_d.entry       = rdata_i;
          pend_d            = 1'b0;
          state_d           = ST_RESP;
        end else begin
          if (pend_q && !prev_vld && !free_found_q) begin
            free_found_d = 1'b1;
            free_d       = prev_q;
          end
          if (addr_q < CNT_W'(SLOTS)) begin
            rd_o.en   = 1'b1;
            rd_o.addr = addr_q[SLOT_W-1:0];
            prev_d    = addr_q[SLOT_W-1:0];
            pend_d    = 1'b1;
            addr_d    = addr_q + CNT_W'(1);
          end else begin
            pend_d  = 1'b0;
            state_d = ST_RESP;
            if ((req_q.command == CMD_PAIR) && free_any) begin
              wr_o.en           = 1'b1;
              wr_o.addr         = free_sel;
              wr_o.data         = new_entry;
              wr_o.set_valid    = 1'b1;
              res_d.status      = STAT_DONE;
              res_d.slot_index  = 8'(free_sel);
              res_d.entry_id    = 8'(free_sel) + 8'd1;
              res_d.entry_valid = 1'b1;
              res_d.entry       = new_entry;
            end
          end
        end
      end

      ST_QREAD: begin
        // An empty slot reads as zeros whatever the memory holds.
        res_d.status      = STAT_DONE;
        res_d.slot_index  = req_q.slot;
        res_d.entry_valid = valid_i[slot_idx];
        res_d.entry_id    = valid_i[slot_idx] ? (req_q.slot + 8'd1) : 8'd0;
        res_d.entry       = valid_i[slot_idx] ? rdata_i : '0;
        state_d           = ST_RESP;
      end

      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    res_o              = res_q;
    res_o.paired_count = count_i;
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == ST_START))
    else $error("accepted word did not start a command");

  a_paired_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status == STAT_PAIRED)) |->
      (res_o.entry_valid && (res_o.entry_id == res_o.slot_index + 8'd1)))
    else $error("already-paired result without a valid entry");

  a_scan_end_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && (addr_q == CNT_W'(SLOTS))) |-> pend_q)
    else $error("scan ended without evaluating the last slot");

endmodule
`default_nettype wire

// File: rtl/core/detector_pairing_table_unit.sv
// Detector pairing table top level: input capture, sequencer, slot store, output register.
// Pair and match run a start state, then the scan, then the result: the scan reads one
//   slot per cycle through the single read port of the slot memory, lowest slot first.
// Delete runs start then response; query start, read, response. A next word is taken in the
//   cycle after the result enters the output register; it can still wait there for the receiver.
// Reset clears the valid marks and the paired count at once; no clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none
module detector_pairing_table_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] command_i,
  input  wire logic [7:0] code_low_i,
  input  wire logic [7:0] code_mid_i,
  input  wire logic [7:0] code_high_i,
  input  wire logic [7:0] detector_kind_i,
  input  wire logic [7:0] zone_kind_i,
  input  wire logic [7:0] slot_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      status_o,
  output logic [7:0]      slot_index_o,
  output logic [7:0]      entry_id_o,
  output logic            entry_valid_o,
  output logic [7:0]      entry_code_low_o,
  output logic [7:0]      entry_code_mid_o,
  output logic [7:0]      entry_code_high_o,
  output logic [7:0]      entry_kind_o,
  output logic [7:0]      entry_zone_o,
  output logic [7:0]      paired_count_o
);
  import dpt_pkg::*;

  req_t             req;
  wr_t              wr;
  rd_t              rd;
  entry_t           rdata;
  logic [SLOTS-1:0] valid;
  logic [7:0]       count;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  logic             out_valid_q;
  res_t             out_q;

  // Pack the input word for the sequencer.
  assign req = '{command: cmd_e'(command_i), code_low: code_low_i, code_mid: code_mid_i,
                 code_high: code_high_i, detector_kind: detector_kind_i,
                 zone_kind: zone_kind_i, slot: slot_i};

  dpt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (req),
    .wr_o        (wr),
    .rd_o        (rd),
    .rdata_i     (rdata),
    .valid_i     (valid),
    .count_i     (count),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  dpt_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata),
    .valid_o (valid),
    .count_o (count)
  );

  // Output register: take a new result when empty or when the held word leaves.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // Hold the payload while the word stalls.
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign slot_index_o      = out_q.slot_index;
  assign entry_id_o        = out_q.entry_id;
  assign entry_valid_o     = out_q.entry_valid;
  assign entry_code_low_o  = out_q.entry.code_low;
  assign entry_code_mid_o  = out_q.entry.code_mid;
  assign entry_code_high_o = out_q.entry.code_high;
  assign entry_kind_o      = out_q.entry.kind;
  assign entry_zone_o      = out_q.entry.zone;
  assign paired_count_o    = out_q.paired_count;

endmodule
`default_nettype wire
